/* hw/rtl/assert_macros.svh */
// Assertion helpers for the downscaler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ADSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ADSC_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define ADSC_ASSERT(lbl, clk, rst_n, prop)
`define ADSC_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* hw/rtl/adsc_pkg.sv */
`timescale 1ns / 1ps
package adsc_pkg;

    localparam logic [1:0] CFG_OLD_WIDTH = 2'd0;
    localparam logic [1:0] CFG_NEW_WIDTH = 2'd1;
    localparam logic [1:0] CFG_CHANNELS  = 2'd2;
    localparam logic [1:0] CFG_SCALE     = 2'd3;

    // one queued item, bin index travels beside it
    typedef struct packed {
        logic       clear_first;
        logic       pass;
        logic       emit;
        logic       row_end;
        logic [1:0] chn;
        logic [9:0] out_col;
        logic [7:0] sample;
    } item_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_UPDATE,
        BK_DIV,
        BK_EMIT
    } back_state_t;

endpackage

/* hw/rtl/adsc_front.sv */
`timescale 1ns / 1ps
module adsc_front #(
    parameter int MAX_NEW_WIDTH = 1024,
    parameter int MAX_OLD_WIDTH = 8192,
    parameter int OW_W          = 14,
    parameter int NW_W          = 11,
    parameter int BIN_W         = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          sample,
    input  logic                frame_start,
    input  logic [OW_W-1:0]     ow_eff,
    input  logic [NW_W-1:0]     nw_eff,
    input  logic [1:0]          ch_eff,
    input  logic [15:0]         scale,
    input  logic                q_full,
    output logic                q_push,
    output adsc_pkg::item_t     q_item,
    output logic [BIN_W-1:0]    q_bin
);

    logic [OW_W-1:0] col_reg, col_next;
    logic [1:0]      chn_reg, chn_next;
    logic [15:0]     row_reg, row_next;
    logic [15:0]     last_out_reg, last_out_next;

    logic            a_valid_reg, a_valid_next;
    logic [7:0]      a_sample_reg;
    logic            a_start_reg;
    logic [OW_W-1:0] a_col_reg;
    logic [1:0]      a_chn_reg;
    logic            a_last_ch_reg, a_last_col_reg;
    logic [15:0]     a_row_reg;

    logic            accept;
    logic [OW_W-1:0] cur_col, col;
    logic [1:0]      cur_chn, chn;
    logic [15:0]     cur_row;
    logic            last_ch, last_col;

    logic [15:0]     srow, last_out_cur;
    logic            is_out, pass;
    logic [BIN_W-1:0] b0, b1;
    logic [31:0]     bin_ext;

    function automatic logic [BIN_W-1:0] bin_of(input logic [OW_W-1:0] c,
                                                input logic [15:0] s,
                                                input logic [NW_W-1:0] nw);
        logic [31:0] p;
        logic [31:0] lim;
        p   = 32'(c) * 32'(s);
        lim = 32'(nw) - 32'd1;
        p   = p >> 16;
        return (p > lim) ? BIN_W'(lim) : BIN_W'(p);
    endfunction

    assign in_stall = a_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = a_valid_reg && !q_full;

    always_comb
    begin
        cur_col  = frame_start ? '0 : col_reg;
        cur_chn  = frame_start ? '0 : chn_reg;
        cur_row  = frame_start ? '0 : row_reg;
        col      = (cur_col >= ow_eff) ? OW_W'(ow_eff - 1'b1) : cur_col;
        chn      = (cur_chn >= ch_eff) ? 2'(ch_eff - 2'd1) : cur_chn;
        last_ch  = (chn == 2'(ch_eff - 2'd1));
        last_col = (col == OW_W'(ow_eff - 1'b1));
        col_next = col;
        chn_next = 2'(chn + 2'd1);
        row_next = cur_row;
        if (last_ch)
        begin
            chn_next = '0;
            if (last_col)
            begin
                col_next = '0;
                if (cur_row != 16'hFFFF)
                    row_next = 16'(cur_row + 16'd1);
            end
            else
            begin
                col_next = OW_W'(col + 1'b1);
            end
        end
        a_valid_next = accept ? 1'b1 : (q_push ? 1'b0 : a_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            chn_reg      <= '0;
            row_reg      <= '0;
            last_out_reg <= '0;
            a_valid_reg  <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            if (accept)
            begin
                col_reg <= col_next;
                chn_reg <= chn_next;
                row_reg <= row_next;
            end
            if (q_push)
                last_out_reg <= last_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_sample_reg   <= sample;
            a_start_reg    <= frame_start;
            a_col_reg      <= col;
            a_chn_reg      <= chn;
            a_last_ch_reg  <= last_ch;
            a_last_col_reg <= last_col;
            a_row_reg      <= cur_row;
        end
    end

    // classify the held item
    always_comb
    begin
        srow          = 16'((32'(a_row_reg) * 32'(scale)) >> 16);
        last_out_cur  = a_start_reg ? '0 : last_out_reg;
        is_out        = srow > last_out_cur;
        pass          = 32'(nw_eff) >= 32'(ow_eff);
        b0            = bin_of(a_col_reg, scale, nw_eff);
        b1            = bin_of(OW_W'(a_col_reg + 1'b1), scale, nw_eff);
        last_out_next = last_out_cur;
        if (a_last_ch_reg && a_last_col_reg && is_out)
            last_out_next = srow;
        bin_ext             = pass ? 32'(a_col_reg) : 32'(b0);
        q_item.clear_first  = a_start_reg;
        q_item.pass         = pass;
        q_item.emit         = !pass && is_out && (a_last_col_reg || (b1 != b0));
        q_item.row_end      = a_last_ch_reg && a_last_col_reg;
        q_item.chn          = a_chn_reg;
        q_item.out_col      = bin_ext[9:0];
        q_item.sample       = a_sample_reg;
        q_bin               = b0;
    end

endmodule

/* hw/rtl/adsc_fifo.sv */
`timescale 1ns / 1ps
module adsc_fifo #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        else if (pop && !push)
            cnt_next = CNT_W'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : PTR_W'(wr_ptr_reg + 1'b1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : PTR_W'(rd_ptr_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

endmodule

/* hw/rtl/adsc_back.sv */
`timescale 1ns / 1ps
module adsc_back #(
    parameter int MAX_NEW_WIDTH = 1024,
    parameter int MAX_CHANNELS  = 3,
    parameter int BIN_W         = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    output logic             q_pop,
    input  adsc_pkg::item_t  q_item,
    input  logic [BIN_W-1:0] q_bin,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       average,
    output logic [9:0]       out_column,
    output logic [1:0]       out_channel,
    output logic             row_end
);

    localparam int DEPTH  = MAX_NEW_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MEM_W  = 49;

    adsc_pkg::back_state_t state_reg, state_next;
    adsc_pkg::item_t       ent_reg;
    logic [BIN_W-1:0]      ent_bin_reg;
    logic                  hold_reg;
    logic [ADDR_W-1:0]     clr_reg;
    logic                  clr_last;

    logic [MEM_W-1:0]      bin_mem [DEPTH];
    logic [MEM_W-1:0]      rd_reg;
    logic [ADDR_W-1:0]     addr;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [MEM_W-1:0]      mem_wdata;

    logic [32:0]           sum_add;
    logic [31:0]           new_sum;
    logic [15:0]           new_cnt;
    logic                  ovf;

    logic [23:0]           rem_reg;
    logic [22:0]           dsh_reg;
    logic [7:0]            quo_reg;
    logic [2:0]            step_reg;

    logic                  out_valid_reg;
    logic [7:0]            avg_reg;
    logic [9:0]            col_reg;
    logic [1:0]            chn_reg;
    logic                  rend_reg;
    logic                  out_free, out_load;

    assign out_valid   = out_valid_reg;
    assign average     = avg_reg;
    assign out_column  = col_reg;
    assign out_channel = chn_reg;
    assign row_end     = rend_reg;

    assign addr     = ADDR_W'(32'(ent_bin_reg) * MAX_CHANNELS + 32'(ent_reg.chn));
    assign clr_last = (clr_reg == ADDR_W'(DEPTH - 1));
    assign out_free = !out_valid_reg || !out_stall;

    // read-modify-write of one bin
    always_comb
    begin
        sum_add = 33'(rd_reg[31:0]) + 33'(ent_reg.sample);
        if (!rd_reg[48])
        begin
            new_sum = 32'(ent_reg.sample);
            new_cnt = 16'd1;
        end
        else
        begin
            new_sum = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
            new_cnt = (rd_reg[47:32] == 16'hFFFF) ? rd_reg[47:32]
                                                   : 16'(rd_reg[47:32] + 16'd1);
        end
        ovf = new_sum >= {8'd0, new_cnt, 8'd0};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            adsc_pkg::BK_CLEAR:
                if (clr_last)
                    state_next = !hold_reg ? adsc_pkg::BK_IDLE
                               : (ent_reg.pass ? adsc_pkg::BK_EMIT : adsc_pkg::BK_READ);
            adsc_pkg::BK_IDLE:
                if (!q_empty)
                    state_next = q_item.clear_first ? adsc_pkg::BK_CLEAR
                               : (q_item.pass ? adsc_pkg::BK_EMIT : adsc_pkg::BK_READ);
            adsc_pkg::BK_READ:
                state_next = adsc_pkg::BK_UPDATE;
            adsc_pkg::BK_UPDATE:
                state_next = !ent_reg.emit ? adsc_pkg::BK_IDLE
                           : (ovf ? adsc_pkg::BK_EMIT : adsc_pkg::BK_DIV);
            adsc_pkg::BK_DIV:
                if (step_reg == 3'd0)
                    state_next = adsc_pkg::BK_EMIT;
            adsc_pkg::BK_EMIT:
                if (out_free)
                    state_next = adsc_pkg::BK_IDLE;
            default:
                state_next = adsc_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = addr;
        mem_wdata = {!ent_reg.emit, new_cnt, new_sum};
        out_load  = 1'b0;
        unique case (state_reg)
            adsc_pkg::BK_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            adsc_pkg::BK_IDLE:   q_pop    = !q_empty;
            adsc_pkg::BK_UPDATE: mem_we   = 1'b1;
            adsc_pkg::BK_EMIT:   out_load = out_free;
            default:             ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= adsc_pkg::BK_CLEAR;
            hold_reg      <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == adsc_pkg::BK_CLEAR)
                clr_reg <= clr_last ? '0 : ADDR_W'(clr_reg + 1'b1);
            if (q_pop)
                hold_reg <= q_item.clear_first;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            bin_mem[mem_waddr] <= mem_wdata;
        if (state_reg == adsc_pkg::BK_READ)
            rd_reg <= bin_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ent_reg     <= q_item;
            ent_bin_reg <= q_bin;
        end
        if (state_reg == adsc_pkg::BK_UPDATE)
        begin
            rem_reg  <= new_sum[23:0];
            dsh_reg  <= {new_cnt, 7'd0};
            quo_reg  <= ovf ? 8'hFF : 8'd0;
            step_reg <= 3'd7;
        end
        else if (state_reg == adsc_pkg::BK_DIV)
        begin
            // restoring division, one quotient bit per cycle
            if (rem_reg >= 24'(dsh_reg))
            begin
                rem_reg <= 24'(rem_reg - 24'(dsh_reg));
                quo_reg <= {quo_reg[6:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[6:0], 1'b0};
            end
            dsh_reg  <= dsh_reg >> 1;
            step_reg <= 3'(step_reg - 3'd1);
        end
        if (out_load)
        begin
            avg_reg  <= ent_reg.pass ? ent_reg.sample : quo_reg;
            col_reg  <= ent_reg.out_col;
            chn_reg  <= ent_reg.chn;
            rend_reg <= ent_reg.row_end;
        end
    end

endmodule

/* hw/rtl/area_average_downscaler.sv */
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// in       in   in_valid/in_stall    sample, frame_start
// out      out  out_valid/out_stall  average, out_column, out_channel, row_end
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Front end classifies one item a cycle unless the queue is full; the bin memory
// unit then takes an item through IDLE, READ and UPDATE when it gives no result,
// IDLE and EMIT for a pass-through result, and IDLE, READ, UPDATE, the 8-step
// divider and EMIT for an averaged result (no divider when the average clamps to 255).
// After reset, and before the first item of each frame, the bin memory is swept:
// all MAX_NEW_WIDTH * MAX_CHANNELS entries (3072 by default) are cleared, with no bin work.
// A stalled output holds the back end; the queue lets the front keep taking items until it fills.
`include "assert_macros.svh"
module area_average_downscaler #(
    parameter int MAX_NEW_WIDTH = 1024,
    parameter int MAX_OLD_WIDTH = 8192,
    parameter int MAX_CHANNELS  = 3,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  sample,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  average,
    output logic [9:0]  out_column,
    output logic [1:0]  out_channel,
    output logic        row_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int OW_W   = $clog2(MAX_OLD_WIDTH + 1);
    localparam int NW_W   = $clog2(MAX_NEW_WIDTH + 1);
    localparam int BIN_W  = (MAX_NEW_WIDTH > 1) ? $clog2(MAX_NEW_WIDTH) : 1;
    localparam int ITEM_W = $bits(adsc_pkg::item_t);
    localparam int Q_W    = ITEM_W + BIN_W;
    localparam int OW_RST = (640 > MAX_OLD_WIDTH) ? MAX_OLD_WIDTH : 640;
    localparam int NW_RST = (320 > MAX_NEW_WIDTH) ? MAX_NEW_WIDTH : 320;
    localparam int CH_RST = (3 > MAX_CHANNELS) ? MAX_CHANNELS : 3;

    function automatic logic [31:0] clampu(input logic [31:0] v,
                                           input logic [31:0] lo,
                                           input logic [31:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // registers hold the clamped widths and channel count; the scale is stored as written
    logic [OW_W-1:0] ow_eff_reg;
    logic [NW_W-1:0] nw_eff_reg;
    logic [1:0]      ch_eff_reg;
    logic [15:0]     scale_reg;
    logic            cfg_we;

    logic              q_push, q_pop, q_full, q_empty;
    adsc_pkg::item_t   f_item, b_item;
    logic [BIN_W-1:0]  f_bin, b_bin;
    logic [Q_W-1:0]    q_wdata, q_rdata;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ow_eff_reg <= OW_W'(OW_RST);
            nw_eff_reg <= NW_W'(NW_RST);
            ch_eff_reg <= 2'(CH_RST);
            scale_reg  <= 16'd32768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                adsc_pkg::CFG_OLD_WIDTH:
                    ow_eff_reg <= OW_W'(clampu(32'(cfg_data[13:0]), 32'd1,
                                               32'(MAX_OLD_WIDTH)));
                adsc_pkg::CFG_NEW_WIDTH:
                    nw_eff_reg <= NW_W'(clampu(32'(cfg_data[10:0]), 32'd1,
                                               32'(MAX_NEW_WIDTH)));
                adsc_pkg::CFG_CHANNELS:
                    ch_eff_reg <= 2'(clampu(32'(cfg_data[1:0]), 32'd1,
                                            32'(MAX_CHANNELS)));
                adsc_pkg::CFG_SCALE:
                    scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    adsc_front #(
        .MAX_NEW_WIDTH (MAX_NEW_WIDTH),
        .MAX_OLD_WIDTH (MAX_OLD_WIDTH),
        .OW_W          (OW_W),
        .NW_W          (NW_W),
        .BIN_W         (BIN_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .frame_start (frame_start),
        .ow_eff      (ow_eff_reg),
        .nw_eff      (nw_eff_reg),
        .ch_eff      (ch_eff_reg),
        .scale       (scale_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (f_item),
        .q_bin       (f_bin)
    );

    assign q_wdata = {f_bin, f_item};
    assign b_item  = q_rdata[ITEM_W-1:0];
    assign b_bin   = q_rdata[Q_W-1:ITEM_W];

    adsc_fifo #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    adsc_back #(
        .MAX_NEW_WIDTH (MAX_NEW_WIDTH),
        .MAX_CHANNELS  (MAX_CHANNELS),
        .BIN_W         (BIN_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_item      (b_item),
        .q_bin       (b_bin),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .average     (average),
        .out_column  (out_column),
        .out_channel (out_channel),
        .row_end     (row_end)
    );

    `ADSC_ASSERT(a_chan_in_range, clk, rst_n, out_valid |-> (out_channel < ch_eff_reg))
    `ADSC_NEVER(a_pass_and_emit, clk, rst_n, q_push && f_item.pass && f_item.emit)
    `ADSC_NEVER(a_queue_flags, clk, rst_n, q_full && q_empty)
    `ADSC_ASSERT(a_stall_only_busy, clk, rst_n, in_stall |-> q_full)

endmodule
